### rtl/lct_pkg.sv
// ----------------------------------------------------------------------------
// lct_pkg: shared types and constants for the label compaction table
// Item structs, table entry layout, state encoding and sizing constants.
// ----------------------------------------------------------------------------
package lct_pkg;

	// table is indexed by the low LABEL_BITS bits of the label value
	localparam int LABEL_BITS  = 16;
	// number of dense codes that can be handed out (2..256)
	localparam int MAX_CODES   = 256;
	localparam int TABLE_DEPTH = 1 << LABEL_BITS;
	localparam int CODE_BITS   = 8;
	// codes-used counter must hold MAX_CODES itself
	localparam int COUNT_BITS  = 9;
	localparam int VALUE_BITS  = 16;

	typedef enum logic {
		LCT_LEARN     = 1'b0,
		LCT_TRANSLATE = 1'b1
	} lct_kind_t;

	typedef struct packed {
		lct_kind_t             kind;
		logic [VALUE_BITS-1:0] label_value;
	} lct_lookup_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		logic                 hit;
		logic                 new_entry;
		logic                 full_res;
	} lct_result_t;

	typedef struct packed {
		logic                 valid;
		logic [CODE_BITS-1:0] code;
	} lct_entry_t;

	localparam int ENTRY_BITS = $bits(lct_entry_t);

	typedef enum logic [1:0] {
		LCT_ST_CLEAR,
		LCT_ST_IDLE,
		LCT_ST_LOOKUP
	} lct_state_t;

	// low LABEL_BITS bits of a label value, zero-extended if the table is wider
	function automatic logic [LABEL_BITS-1:0] label_index(input logic [VALUE_BITS-1:0] value);
		logic [LABEL_BITS+VALUE_BITS-1:0] wide;
		wide = {{LABEL_BITS{1'b0}}, value};
		return wide[LABEL_BITS-1:0];
	endfunction

endpackage

### rtl/lct_ram.sv
// ----------------------------------------------------------------------------
// lct_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/label_compaction_table_unit.sv
// ----------------------------------------------------------------------------
// label_compaction_table_unit: dense relabeling of raw voxel label values
// Direct-mapped label table in one synchronous RAM, learn and translate modes.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the whole table clear, one entry per cycle,
// writing all 2^LABEL_BITS entries (65536 with the default sizing) while
// lookup_ready stays low. Each lookup item then passes through IDLE, which
// issues the table read, and LOOKUP, which uses the registered read data and
// writes the entry back; a new item is not taken until the last one has
// finished its write-back. A result sits in an output register; the next
// lookup item is taken while it waits, and only the write-back cycle stalls
// on a result that was not yet taken.
// In learn mode a label seen for the first time gets the next dense code
// (0, 1, 2, ... in order of first appearance) and new_entry is set; once
// MAX_CODES codes are out a learn miss reports full_res with code 0 and
// inserts nothing. In translate mode the table is only read: a miss returns
// code 0 with hit clear.
module label_compaction_table_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                lookup_valid,
	output logic                lookup_ready,
	input  lct_pkg::lct_lookup_t lookup,
	output logic                result_valid,
	input  logic                result_ready,
	output lct_pkg::lct_result_t result
);

	lct_pkg::lct_state_t state_q, state_d;

	// clearing sweep address
	logic [lct_pkg::LABEL_BITS-1:0]  clr_q;
	// item held during its lookup
	lct_pkg::lct_lookup_t            item_q;
	logic [lct_pkg::COUNT_BITS-1:0]  codes_used_q;
	lct_pkg::lct_result_t            result_q;
	logic                            result_valid_q;

	// RAM ports
	logic                            ram_we;
	logic [lct_pkg::LABEL_BITS-1:0]  ram_waddr;
	lct_pkg::lct_entry_t             ram_wdata;
	logic [lct_pkg::LABEL_BITS-1:0]  ram_raddr;
	lct_pkg::lct_entry_t             ram_rdata;

	// datapath decisions for the item in lookup
	logic                            accept;
	logic                            slot_free;
	logic                            finish;
	logic                            clr_last;
	logic                            codes_left;
	logic                            insert;
	lct_pkg::lct_result_t            result_d;

	assign accept     = lookup_valid && lookup_ready;
	assign slot_free  = !result_valid_q || result_ready;
	assign clr_last   = (clr_q == '1);
	assign codes_left = (codes_used_q < lct_pkg::COUNT_BITS'(lct_pkg::MAX_CODES));

	// ---------------- table ----------------
	lct_ram #(
		.WIDTH (lct_pkg::ENTRY_BITS),
		.DEPTH (lct_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// read address: the incoming label while waiting for an item, else the
	// held one so the read data stays valid through an output stall
	always_comb begin
		if (state_q == lct_pkg::LCT_ST_IDLE) begin
			ram_raddr = lct_pkg::label_index(lookup.label_value);
		end else begin
			ram_raddr = lct_pkg::label_index(item_q.label_value);
		end
	end

	// ---------------- result of the item in lookup ----------------
	always_comb begin
		result_d = '0;
		insert   = 1'b0;
		if (ram_rdata.valid) begin
			result_d.code = ram_rdata.code;
			result_d.hit  = 1'b1;
		end else if (item_q.kind == lct_pkg::LCT_LEARN) begin
			if (codes_left) begin
				result_d.code      = codes_used_q[lct_pkg::CODE_BITS-1:0];
				result_d.new_entry = 1'b1;
				insert             = 1'b1;
			end else begin
				result_d.full_res  = 1'b1;
			end
		end
	end

	// ---------------- state machine: next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lct_pkg::LCT_ST_CLEAR: begin
				if (clr_last) begin
					state_d = lct_pkg::LCT_ST_IDLE;
				end
			end
			lct_pkg::LCT_ST_IDLE: begin
				if (lookup_valid) begin
					state_d = lct_pkg::LCT_ST_LOOKUP;
				end
			end
			lct_pkg::LCT_ST_LOOKUP: begin
				if (slot_free) begin
					state_d = lct_pkg::LCT_ST_IDLE;
				end
			end
			default: state_d = lct_pkg::LCT_ST_CLEAR;
		endcase
	end

	// ---------------- state machine: outputs ----------------
	always_comb begin
		lookup_ready = 1'b0;
		finish       = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = lct_pkg::label_index(item_q.label_value);
		ram_wdata    = '0;
		unique case (state_q)
			lct_pkg::LCT_ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			lct_pkg::LCT_ST_IDLE: begin
				lookup_ready = 1'b1;
			end
			lct_pkg::LCT_ST_LOOKUP: begin
				finish          = slot_free;
				ram_we          = slot_free && insert;
				ram_wdata.valid = 1'b1;
				ram_wdata.code  = result_d.code;
			end
			default: begin
				lookup_ready = 1'b0;
			end
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= lct_pkg::LCT_ST_CLEAR;
			clr_q          <= '0;
			codes_used_q   <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lct_pkg::LCT_ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (finish && insert) begin
				codes_used_q <= codes_used_q + 1'b1;
			end
			if (finish) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= lookup;
		end
		if (finish) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### rtl/lct_checker.sv
// ----------------------------------------------------------------------------
// lct_checker: port-level checks for label_compaction_table_unit
// Watches the lookup and result channels; bound to the top level below.
// ----------------------------------------------------------------------------
module lct_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 lookup_valid,
	input logic                 lookup_ready,
	input lct_pkg::lct_lookup_t lookup,
	input logic                 result_valid,
	input logic                 result_ready,
	input lct_pkg::lct_result_t result
);

	// a waiting result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	// one item in flight: no lookup taken in the cycle after one was taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		lookup_valid && lookup_ready |=> !lookup_ready)
		else $error("lookup accepted back to back");

	// hit, new entry and full are mutually exclusive
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $countones({result.hit, result.new_entry, result.full_res}) <= 1)
		else $error("conflicting result flags");

	// a result that is neither a hit nor a new entry carries code 0
	a_miss_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.hit && !result.new_entry |-> result.code == '0)
		else $error("nonzero code on miss");

endmodule

bind label_compaction_table_unit lct_checker u_lct_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.lookup_valid (lookup_valid),
	.lookup_ready (lookup_ready),
	.lookup       (lookup),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
